[rtl/orr_pkg.sv]
// Shared types, constants and fixed-point helpers for the offset polygon ray router.
package orr_pkg;

    localparam int MAX_SHAPES   = 8;
    localparam int MAX_VERTICES = 16;

    // table geometry
    localparam int SW    = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int SCW   = $clog2(MAX_SHAPES + 1);
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int VCW   = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_SHAPES * MAX_VERTICES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // datapath widths
    localparam int CW        = 28;  // offset / far coordinates and differences
    localparam int MW        = 28;  // multiplier operands
    localparam int PW        = 2 * MW;
    localparam int WW        = 60;  // det, na, nb
    localparam int FRAC_BITS = 24;
    localparam int QW        = FRAC_BITS + 1;

    localparam logic [QW-1:0]          ALPHA_ONE = QW'(1) << FRAC_BITS;
    localparam logic signed [MW-1:0]   NUDGE     = 167772;  // 0.01 in Q0.24
    localparam logic signed [CW-1:0]   SAT_HI    = 8388607;
    localparam logic signed [CW-1:0]   SAT_LO    = -8388608;

    // function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ROUTE = 1'b1;

    // status codes
    localparam logic [1:0] ST_PATH   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_DROP   = 2'd2;

    typedef struct packed {
        logic               func;
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic               shape_end;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] goal_x;
        logic signed [23:0] goal_y;
        logic [15:0]        radius;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [23:0] path_x;
        logic signed [23:0] path_y;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
    } vtx_t;

    // round(p / 2^14), half up
    function automatic logic signed [CW-1:0] round14(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = (PW+1)'(p);
        t = t + 8192;
        t = t >>> 14;
        return t[CW-1:0];
    endfunction

    // round(p / 2^24), half up
    function automatic logic signed [CW-1:0] round24(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = (PW+1)'(p);
        t = t + 8388608;
        t = t >>> 24;
        return t[CW-1:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = v;
        if (v > SAT_HI)
            t = SAT_HI;
        if (v < SAT_LO)
            t = SAT_LO;
        return t[23:0];
    endfunction

    function automatic logic [AW-1:0] slot(input logic [SW-1:0] s, input logic [VW-1:0] i);
        return AW'(int'(s) * MAX_VERTICES + int'(i));
    endfunction

endpackage

[rtl/orr_mul.sv]
// Shared signed multiplier with registered product.
module orr_mul
    import orr_pkg::*;
(
    input  logic                 clk,
    input  logic signed [MW-1:0] a,
    input  logic signed [MW-1:0] b,
    output logic signed [PW-1:0] p
);

    logic signed [PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

[rtl/orr_div.sv]
// Restoring divider: one quotient bit per cycle, returns num/den as Q1.24 clamped at one.
module orr_div
    import orr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WW-1:0]     num,
    input  logic [WW-1:0]     den,
    output logic              done,
    output logic [QW-1:0]     quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [WW:0]       rem_reg;
    logic [WW-1:0]     den_reg;
    logic [QW-1:0]     q_reg;
    logic [WW:0]       rem2;

    assign rem2 = {rem_reg[WW-1:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                den_reg <= den;
                rem_reg <= {1'b0, num};
                q_reg   <= '0;
                if (num >= den)
                begin
                    q_reg    <= ALPHA_ONE;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg  <= 5'(FRAC_BITS);
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                // one shift-subtract step
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_reg <= rem2 - {1'b0, den_reg};
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2;
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

[rtl/offset_polygon_ray_route.sv]
// Load item: a single result. Route item: one cast runs over S closed polygons and their E
// stored edges (one product per cycle from the shared multiplier, the divider runs on each
// edge that passes the range check); a hit on the first cast adds the near and far hit points
// and a second cast, then one result per walked vertex.
// One item at a time; each result waits on the output register; registered memory read.
// Reset (async, rst_n low) empties the polygon table; vertex memory contents are not cleared.
module offset_polygon_ray_route
    import orr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [5:0] {
        S_IDLE, S_EMIT, C_INIT, C_SHP,
        E_RD3, E_LD3, E_OX3, E_OY3, E_OX4, E_OY4, E_DIF,
        M1, M2, M3, M4, M5, M6, M7,
        E_CHK, E_DIV, E_NEXT, C_DONE,
        F1, F2, F3, F4, F5,
        W_CHK, W_RD, W_LD, W_OX, W_OY
    } state_t;

    state_t state_reg;
    state_t ret_reg;

    // vertex memory
    vtx_t    mem [DEPTH];
    vtx_t    mem_rd_reg;
    logic    mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    // table bookkeeping
    logic [VCW-1:0] shape_sizes_reg [MAX_SHAPES];
    logic [SCW-1:0] shape_count_reg;
    logic [VCW-1:0] fill_count_reg;

    // cast state
    logic signed [CW-1:0] ax_reg, ay_reg, dx_reg, dy_reg, goal_x_reg, goal_y_reg;
    logic [15:0]          radius_reg;
    logic                 pass_reg;
    logic [SCW-1:0]       s_reg;
    logic [VW-1:0]        i_reg;
    vtx_t                 v3_reg, v4_reg;
    logic signed [CW-1:0] p3x_reg, p3y_reg, p4x_reg, p4y_reg;
    logic signed [CW-1:0] ex_reg, ey_reg, gx_reg, gy_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [WW-1:0] det_reg, na_reg, nb_reg;
    logic                 hit_reg;
    logic [QW-1:0]        alpha_reg;
    logic [SW-1:0]        best_shape_reg;
    logic [VW-1:0]        best_face_reg;
    logic [SW-1:0]        c1_shape_reg;
    logic [VW-1:0]        c1_face_reg;
    logic signed [CW-1:0] nx_reg, ny_reg, fx_reg;
    logic [VW-1:0]        f_reg;
    logic [VCW-1:0]       guard_reg;

    // pending result
    logic [1:0]           pend_status_reg;
    logic signed [CW-1:0] pend_x_reg, pend_y_reg;
    logic                 pend_last_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    // shared units
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic                 div_start, div_done;
    logic [WW-1:0]        div_num, div_den;
    logic [QW-1:0]        div_q;

    orr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    orr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    // derived values
    logic [VCW-1:0]       cur_n;
    logic [VW-1:0]        j_idx;
    logic [VCW-1:0]       walk_n;
    logic signed [MW-1:0] r_op;
    logic signed [MW-1:0] a_lo, a_hi;
    logic                 det_neg;
    logic signed [WW-1:0] det_a, na_a, nb_a;
    logic                 edge_ok;
    logic                 load_fit;
    logic                 load_take;

    assign cur_n   = shape_sizes_reg[s_reg[SW-1:0]];
    assign j_idx   = ((VCW'(i_reg) + VCW'(1)) == cur_n) ? '0 : i_reg + VW'(1);
    assign walk_n  = shape_sizes_reg[c1_shape_reg];
    assign r_op    = MW'($signed({1'b0, radius_reg}));
    assign a_lo    = MW'($signed({1'b0, alpha_reg})) - NUDGE;
    assign a_hi    = MW'($signed({1'b0, alpha_reg})) + NUDGE;
    assign det_neg = det_reg < 0;
    assign det_a   = det_neg ? -det_reg : det_reg;
    assign na_a    = det_neg ? -na_reg : na_reg;
    assign nb_a    = det_neg ? -nb_reg : nb_reg;
    assign edge_ok = (det_reg != 0) && (na_a >= 0) && (na_a <= det_a)
                     && (nb_a >= 0) && (nb_a <= det_a);
    assign div_num = na_a;
    assign div_den = det_a;
    assign div_start = (state_reg == E_CHK) && edge_ok;

    assign load_fit  = (shape_count_reg < SCW'(MAX_SHAPES));
    assign load_take = req_valid && req_ready && (req.func == FUNC_LOAD);
    assign mem_we    = load_take && load_fit && (fill_count_reg < VCW'(MAX_VERTICES));
    assign mem_waddr = slot(shape_count_reg[SW-1:0], fill_count_reg[VW-1:0]);

    // multiplier operands and read address by step
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mem_raddr = slot(s_reg[SW-1:0], i_reg);
        case (state_reg)
            E_LD3:
            begin
                mul_a     = MW'(mem_rd_reg.nx);
                mul_b     = r_op;
                mem_raddr = slot(s_reg[SW-1:0], j_idx);
            end
            E_OX3:
            begin
                mul_a = MW'(v3_reg.ny);
                mul_b = r_op;
            end
            E_OY3:
            begin
                mul_a = MW'(v4_reg.nx);
                mul_b = r_op;
            end
            E_OX4:
            begin
                mul_a = MW'(v4_reg.ny);
                mul_b = r_op;
            end
            M1:
            begin
                mul_a = MW'(ey_reg);
                mul_b = MW'(dx_reg);
            end
            M2:
            begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(dy_reg);
            end
            M3:
            begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(gy_reg);
            end
            M4:
            begin
                mul_a = MW'(ey_reg);
                mul_b = MW'(gx_reg);
            end
            M5:
            begin
                mul_a = MW'(dx_reg);
                mul_b = MW'(gy_reg);
            end
            M6:
            begin
                mul_a = MW'(dy_reg);
                mul_b = MW'(gx_reg);
            end
            F1:
            begin
                mul_a = a_lo;
                mul_b = MW'(dx_reg);
            end
            F2:
            begin
                mul_a = a_lo;
                mul_b = MW'(dy_reg);
            end
            F3:
            begin
                mul_a = a_hi;
                mul_b = MW'(dx_reg);
            end
            F4:
            begin
                mul_a = a_hi;
                mul_b = MW'(dy_reg);
            end
            W_RD:
            begin
                mem_raddr = slot(c1_shape_reg, f_reg);
            end
            W_LD:
            begin
                mul_a = MW'(mem_rd_reg.nx);
                mul_b = r_op;
            end
            W_OX:
            begin
                mul_a = MW'(v3_reg.ny);
                mul_b = r_op;
            end
            default:
            begin
            end
        endcase
    end

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= '{px: req.vert_x, py: req.vert_y, nx: req.norm_x, ny: req.norm_y};
        mem_rd_reg <= mem[mem_raddr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ret_reg         <= S_IDLE;
            shape_count_reg <= '0;
            fill_count_reg  <= '0;
            for (int k = 0; k < MAX_SHAPES; k++)
                shape_sizes_reg[k] <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
            pend_status_reg <= ST_PATH;
            pend_x_reg      <= '0;
            pend_y_reg      <= '0;
            pend_last_reg   <= 1'b0;
            ax_reg <= '0; ay_reg <= '0; dx_reg <= '0; dy_reg <= '0;
            goal_x_reg <= '0; goal_y_reg <= '0; radius_reg <= '0;
            pass_reg <= 1'b0; s_reg <= '0; i_reg <= '0;
            v3_reg <= '0; v4_reg <= '0;
            p3x_reg <= '0; p3y_reg <= '0; p4x_reg <= '0; p4y_reg <= '0;
            ex_reg <= '0; ey_reg <= '0; gx_reg <= '0; gy_reg <= '0;
            acc_reg <= '0; det_reg <= '0; na_reg <= '0; nb_reg <= '0;
            hit_reg <= 1'b0; alpha_reg <= '0;
            best_shape_reg <= '0; best_face_reg <= '0;
            c1_shape_reg <= '0; c1_face_reg <= '0;
            nx_reg <= '0; ny_reg <= '0; fx_reg <= '0;
            f_reg <= '0; guard_reg <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req.func == FUNC_LOAD)
                        begin
                            pend_status_reg <= ST_DROP;
                            if (load_fit)
                            begin
                                if (mem_we)
                                    pend_status_reg <= ST_ACCEPT;
                                if (req.shape_end)
                                begin
                                    shape_sizes_reg[shape_count_reg[SW-1:0]] <=
                                        fill_count_reg + VCW'(mem_we);
                                    shape_count_reg <= shape_count_reg + SCW'(1);
                                    fill_count_reg  <= '0;
                                end
                                else
                                    fill_count_reg <= fill_count_reg + VCW'(mem_we);
                            end
                            pend_x_reg    <= '0;
                            pend_y_reg    <= '0;
                            pend_last_reg <= 1'b1;
                            ret_reg       <= S_IDLE;
                        end
                        else
                        begin
                            // route: emit start, then first cast
                            ax_reg          <= CW'(req.start_x);
                            ay_reg          <= CW'(req.start_y);
                            goal_x_reg      <= CW'(req.goal_x);
                            goal_y_reg      <= CW'(req.goal_y);
                            radius_reg      <= req.radius;
                            pass_reg        <= 1'b0;
                            pend_status_reg <= ST_PATH;
                            pend_x_reg      <= CW'(req.start_x);
                            pend_y_reg      <= CW'(req.start_y);
                            pend_last_reg   <= 1'b0;
                            ret_reg         <= C_INIT;
                        end
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg.status <= pend_status_reg;
                        rsp_reg.path_x <= sat24(pend_x_reg);
                        rsp_reg.path_y <= sat24(pend_y_reg);
                        rsp_reg.last   <= pend_last_reg;
                        rsp_valid_reg  <= 1'b1;
                        state_reg      <= pend_last_reg ? S_IDLE : ret_reg;
                    end
                end

                C_INIT:
                begin
                    dx_reg    <= goal_x_reg - ax_reg;
                    dy_reg    <= goal_y_reg - ay_reg;
                    hit_reg   <= 1'b0;
                    s_reg     <= '0;
                    state_reg <= C_SHP;
                end

                C_SHP:
                begin
                    i_reg <= '0;
                    if (s_reg < shape_count_reg)
                    begin
                        if (cur_n == '0)
                            s_reg <= s_reg + SCW'(1);
                        else
                            state_reg <= E_RD3;
                    end
                    else
                        state_reg <= C_DONE;
                end

                E_RD3: state_reg <= E_LD3;

                E_LD3:
                begin
                    v3_reg    <= mem_rd_reg;
                    state_reg <= E_OX3;
                end

                E_OX3:
                begin
                    p3x_reg   <= CW'(v3_reg.px) + round14(prod);
                    v4_reg    <= mem_rd_reg;
                    state_reg <= E_OY3;
                end

                E_OY3:
                begin
                    p3y_reg   <= CW'(v3_reg.py) + round14(prod);
                    state_reg <= E_OX4;
                end

                E_OX4:
                begin
                    p4x_reg   <= CW'(v4_reg.px) + round14(prod);
                    state_reg <= E_OY4;
                end

                E_OY4:
                begin
                    p4y_reg   <= CW'(v4_reg.py) + round14(prod);
                    state_reg <= E_DIF;
                end

                E_DIF:
                begin
                    ex_reg    <= p4x_reg - p3x_reg;
                    ey_reg    <= p4y_reg - p3y_reg;
                    gx_reg    <= ax_reg - p3x_reg;
                    gy_reg    <= ay_reg - p3y_reg;
                    state_reg <= M1;
                end

                M1: state_reg <= M2;
                M2:
                begin
                    acc_reg   <= prod;
                    state_reg <= M3;
                end
                M3:
                begin
                    det_reg   <= WW'(acc_reg) - WW'(prod);
                    state_reg <= M4;
                end
                M4:
                begin
                    acc_reg   <= prod;
                    state_reg <= M5;
                end
                M5:
                begin
                    na_reg    <= WW'(acc_reg) - WW'(prod);
                    state_reg <= M6;
                end
                M6:
                begin
                    acc_reg   <= prod;
                    state_reg <= M7;
                end
                M7:
                begin
                    nb_reg    <= WW'(acc_reg) - WW'(prod);
                    state_reg <= E_CHK;
                end

                E_CHK: state_reg <= edge_ok ? E_DIV : E_NEXT;

                E_DIV:
                begin
                    if (div_done)
                    begin
                        // strictly nearer wins, ties keep the earlier edge
                        if (!hit_reg || (div_q < alpha_reg))
                        begin
                            hit_reg        <= 1'b1;
                            alpha_reg      <= div_q;
                            best_shape_reg <= s_reg[SW-1:0];
                            best_face_reg  <= i_reg;
                        end
                        state_reg <= E_NEXT;
                    end
                end

                E_NEXT:
                begin
                    if ((VCW'(i_reg) + VCW'(1)) < cur_n)
                    begin
                        i_reg     <= i_reg + VW'(1);
                        state_reg <= E_RD3;
                    end
                    else
                    begin
                        s_reg     <= s_reg + SCW'(1);
                        state_reg <= C_SHP;
                    end
                end

                C_DONE:
                begin
                    pend_status_reg <= ST_PATH;
                    if (!pass_reg)
                    begin
                        if (!hit_reg)
                        begin
                            pend_x_reg    <= goal_x_reg;
                            pend_y_reg    <= goal_y_reg;
                            pend_last_reg <= 1'b1;
                            state_reg     <= S_EMIT;
                        end
                        else
                            state_reg <= F1;
                    end
                    else if (!hit_reg || (best_shape_reg != c1_shape_reg))
                    begin
                        pend_x_reg    <= nx_reg;
                        pend_y_reg    <= ny_reg;
                        pend_last_reg <= 1'b1;
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        f_reg     <= c1_face_reg;
                        guard_reg <= '0;
                        state_reg <= W_CHK;
                    end
                end

                // near and far points of the first hit
                F1: state_reg <= F2;
                F2:
                begin
                    nx_reg    <= ax_reg + round24(prod);
                    state_reg <= F3;
                end
                F3:
                begin
                    ny_reg    <= ay_reg + round24(prod);
                    state_reg <= F4;
                end
                F4:
                begin
                    fx_reg    <= ax_reg + round24(prod);
                    state_reg <= F5;
                end
                F5:
                begin
                    ax_reg       <= fx_reg;
                    ay_reg       <= ay_reg + round24(prod);
                    c1_shape_reg <= best_shape_reg;
                    c1_face_reg  <= best_face_reg;
                    pass_reg     <= 1'b1;
                    state_reg    <= C_INIT;
                end

                // walk offset vertices backward from the entry face
                W_CHK:
                begin
                    if ((f_reg != best_face_reg) && (guard_reg < VCW'(MAX_VERTICES)))
                        state_reg <= W_RD;
                    else
                    begin
                        pend_x_reg    <= goal_x_reg;
                        pend_y_reg    <= goal_y_reg;
                        pend_last_reg <= 1'b1;
                        state_reg     <= S_EMIT;
                    end
                end

                W_RD: state_reg <= W_LD;

                W_LD:
                begin
                    v3_reg    <= mem_rd_reg;
                    state_reg <= W_OX;
                end

                W_OX:
                begin
                    p3x_reg   <= CW'(v3_reg.px) + round14(prod);
                    state_reg <= W_OY;
                end

                W_OY:
                begin
                    pend_x_reg    <= p3x_reg;
                    pend_y_reg    <= CW'(v3_reg.py) + round14(prod);
                    pend_last_reg <= 1'b0;
                    f_reg         <= (f_reg == '0) ? VW'(walk_n - VCW'(1)) : f_reg - VW'(1);
                    guard_reg     <= guard_reg + VCW'(1);
                    ret_reg       <= W_CHK;
                    state_reg     <= S_EMIT;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[tb/sv/offset_polygon_ray_route_tb.sv]
// Testbench for offset_polygon_ray_route: polygon loads and route queries checked by a predictor.
module offset_polygon_ray_route_tb
    import orr_pkg::*;
();

    localparam longint NUDGE_Q = 167772;
    localparam longint ONE_Q   = 16777216;
    localparam int     WDOG    = 200000;

    // Expected route points and load statuses, checked in order
    class path_board;
        rsp_t pending[$];
        int   errors;

        function void note(rsp_t r);
            pending = {pending, r};
        endfunction

        function void report(string fld, longint got, longint want);
            $display("ERROR %s got %0h want %0h", fld, got, want);
            errors++;
        endfunction

        function void check(rsp_t got);
            rsp_t exp_r;
            if (pending.size() == 0)
            begin
                report("unexpected item", longint'(got), 0);
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status) report("status", got.status, exp_r.status);
            if (got.path_x !== exp_r.path_x) report("path_x", got.path_x, exp_r.path_x);
            if (got.path_y !== exp_r.path_y) report("path_y", got.path_y, exp_r.path_y);
            if (got.last !== exp_r.last) report("last", got.last, exp_r.last);
        endfunction
    endclass

    logic clk, rst_n, req_valid, req_ready, rsp_valid, rsp_ready;
    req_t req;
    rsp_t rsp;
    path_board board;
    int send_idle, recv_idle;
    bit hold_off;
    int quiet;

    // predictor state
    longint tab_px[DEPTH], tab_py[DEPTH], tab_nx[DEPTH], tab_ny[DEPTH];
    int sizes[MAX_SHAPES];
    int n_shapes, n_fill;

    offset_polygon_ray_route DUT (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic void off_vertex(int sl, longint r, output longint x, output longint y);
        x = tab_px[sl] + fl_shift(tab_nx[sl] * r + 8192, 14);
        y = tab_py[sl] + fl_shift(tab_ny[sl] * r + 8192, 14);
    endfunction

    function automatic longint alpha_q24(longint num, longint den);
        longint rem, q;
        rem = num;
        q = 0;
        if (num >= den) return ONE_Q;
        for (int i = 0; i < 24; i++)
        begin
            rem = rem <<< 1;
            q = q <<< 1;
            if (rem >= den)
            begin
                rem -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    // Nearest edge crossing of segment a->b against all closed offset polygons
    function automatic void ray_cast(longint ax, longint ay, longint bx, longint by, longint r,
                                     output bit hit, output int shp, output int face,
                                     output longint nx, output longint ny,
                                     output longint fx, output longint fy);
        longint dx, dy, p3x, p3y, p4x, p4y, ex, ey, gx, gy, det, na, nb, al, best, a;
        int n, j;
        dx = bx - ax;
        dy = by - ay;
        hit = 0;
        best = 0;
        shp = 0; face = 0; nx = 0; ny = 0; fx = 0; fy = 0;
        for (int s = 0; s < n_shapes; s++)
        begin
            n = sizes[s];
            for (int i = 0; i < n; i++)
            begin
                j = (i + 1 == n) ? 0 : i + 1;
                off_vertex(s * MAX_VERTICES + i, r, p3x, p3y);
                off_vertex(s * MAX_VERTICES + j, r, p4x, p4y);
                ex = p4x - p3x; ey = p4y - p3y;
                gx = ax - p3x; gy = ay - p3y;
                det = ey * dx - ex * dy;
                if (det == 0) continue;
                na = ex * gy - ey * gx;
                nb = dx * gy - dy * gx;
                if (det < 0)
                begin
                    det = -det; na = -na; nb = -nb;
                end
                if (na < 0 || na > det || nb < 0 || nb > det) continue;
                al = alpha_q24(na, det);
                if (hit && !(al < best)) continue;
                hit = 1; best = al; shp = s; face = i;
                a = al - NUDGE_Q;
                nx = ax + fl_shift(a * dx + (1 <<< 23), 24);
                ny = ay + fl_shift(a * dy + (1 <<< 23), 24);
                a = al + NUDGE_Q;
                fx = ax + fl_shift(a * dx + (1 <<< 23), 24);
                fy = ay + fl_shift(a * dy + (1 <<< 23), 24);
            end
        end
    endfunction

    function automatic rsp_t mk(logic [1:0] st, longint x, longint y);
        rsp_t o;
        o.status = st;
        o.path_x = clamp24(x);
        o.path_y = clamp24(y);
        o.last = 0;
        return o;
    endfunction

    // Works out the results of one accepted item
    function automatic void predict_route(req_t q);
        rsp_t outs[$];
        bit h1, h2;
        int s1, f1, s2, f2, f, g, n;
        longint nx1, ny1, fx1, fy1, nx2, ny2, fx2, fy2, vx, vy, sx, sy, gx, gy, r;
        logic [1:0] st;
        if (q.func == FUNC_LOAD)
        begin
            st = ST_DROP;
            if (n_shapes < MAX_SHAPES)
            begin
                if (n_fill < MAX_VERTICES)
                begin
                    tab_px[n_shapes * MAX_VERTICES + n_fill] = longint'(q.vert_x);
                    tab_py[n_shapes * MAX_VERTICES + n_fill] = longint'(q.vert_y);
                    tab_nx[n_shapes * MAX_VERTICES + n_fill] = longint'(q.norm_x);
                    tab_ny[n_shapes * MAX_VERTICES + n_fill] = longint'(q.norm_y);
                    n_fill++;
                    st = ST_ACCEPT;
                end
                if (q.shape_end)
                begin
                    sizes[n_shapes] = n_fill;
                    n_shapes++;
                    n_fill = 0;
                end
            end
            outs = {outs, mk(st, 0, 0)};
        end
        else
        begin
            sx = longint'(q.start_x); sy = longint'(q.start_y);
            gx = longint'(q.goal_x); gy = longint'(q.goal_y);
            r = longint'(q.radius);
            outs = {outs, mk(ST_PATH, sx, sy)};
            ray_cast(sx, sy, gx, gy, r, h1, s1, f1, nx1, ny1, fx1, fy1);
            if (!h1)
                outs = {outs, mk(ST_PATH, gx, gy)};
            else
            begin
                ray_cast(fx1, fy1, gx, gy, r, h2, s2, f2, nx2, ny2, fx2, fy2);
                if (!h2 || s2 != s1)
                    outs = {outs, mk(ST_PATH, nx1, ny1)};
                else
                begin
                    n = sizes[s1];
                    f = f1;
                    g = 0;
                    while (f != f2 && g < MAX_VERTICES)
                    begin
                        off_vertex(s1 * MAX_VERTICES + f, r, vx, vy);
                        outs = {outs, mk(ST_PATH, vx, vy)};
                        f = (f == 0) ? n - 1 : f - 1;
                        g++;
                    end
                    outs = {outs, mk(ST_PATH, gx, gy)};
                end
            end
        end
        outs[outs.size() - 1].last = 1;
        foreach (outs[i]) board.note(outs[i]);
    endfunction

    // Hands one item to the block, then waits for acceptance
    task automatic send_item(req_t q);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 0;
            @(posedge clk);
        end
        req_valid <= 1;
        req <= q;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        predict_route(q);
    endtask

    function automatic req_t blank();
        req_t q;
        q = '0;
        return q;
    endfunction

    task automatic load_vertex(int x, int y, int nx, int ny, bit last_v);
        req_t q;
        q = blank();
        q.func = FUNC_LOAD;
        q.vert_x = 24'(x); q.vert_y = 24'(y); q.norm_x = 16'(nx); q.norm_y = 16'(ny);
        q.shape_end = last_v;
        send_item(q);
    endtask

    task automatic route(int sx, int sy, int gx, int gy, int r);
        req_t q;
        q = blank();
        q.func = FUNC_ROUTE;
        q.start_x = 24'(sx); q.start_y = 24'(sy); q.goal_x = 24'(gx); q.goal_y = 24'(gy);
        q.radius = 16'(r);
        send_item(q);
    endtask

    // Square obstacle of half side h centered at (cx, cy), Q15.8 units
    task automatic load_box(int cx, int cy, int h);
        load_vertex(cx - h, cy - h, -11585, -11585, 0);
        load_vertex(cx + h, cy - h, 11585, -11585, 0);
        load_vertex(cx + h, cy + h, 11585, 11585, 0);
        load_vertex(cx - h, cy + h, -11585, 11585, 1);
    endtask

    task automatic rand_route();
        int c;
        c = $urandom_range(7);
        if (c == 0)
            route($urandom, $urandom, $urandom, $urandom, $urandom);
        else
            route($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                  $urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                  $urandom_range(1024));
    endtask

    task automatic drain();
        req_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Receiver: random stalls, long hold-off on request
    initial
    begin
        rsp_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp_ready <= 0;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready) board.check(rsp);
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || hold_off)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= WDOG)
            begin
                $display("FAIL offset_polygon_ray_route");
                $finish;
            end
        end
    end

    initial
    begin
        int ph, cnt;
        board = new();
        req_valid = 0;
        req = '0;
        rst_n = 0;
        quiet = 0;
        hold_off = 0;
        send_idle = 0;
        recv_idle = 0;
        n_shapes = 0;
        n_fill = 0;
        foreach (sizes[i]) sizes[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: routes with empty table, boxes, walks, extremes
        route(0, 0, 2560, 0, 0);
        route(-8388608, -8388608, 8388607, 8388607, 65535);
        load_box(0, 0, 512);
        route(-2048, 0, 2048, 0, 0);
        route(-2048, 100, 2048, -100, 256);
        route(-2048, 2048, 2048, 2048, 0);
        route(-2048, 0, 0, 0, 0);
        route(0, -2048, 0, 2048, 65535);
        load_vertex(1000, 1000, 0, 0, 0);
        load_vertex(1000, 1000, 0, 0, 1);
        load_vertex(8388607, -8388608, 32767, -32768, 0);
        load_vertex(-8388608, 8388607, -32768, 32767, 1);
        route(3000, 3000, -3000, -3000, 100);
        drain();

        // random phases: fill the table, route heavily
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 47 : 34) : 0;
            recv_idle = (ph == 2 || ph == 3) ? ((ph == 2) ? 47 : 34) : 0;
            if (ph == 2) hold_off = 1;
            cnt = 0;
            while (cnt < 95)
            begin
                if ($urandom_range(9) < 2 && n_shapes < MAX_SHAPES)
                begin
                    // shape with random size; sometimes overfill
                    int nv;
                    int cx, cy;
                    nv = $urandom_range(3, 18);
                    cx = $urandom_range(6000) - 3000;
                    cy = $urandom_range(6000) - 3000;
                    for (int k = 0; k < nv; k++)
                        load_vertex(cx + $urandom_range(800) - 400, cy + $urandom_range(800) - 400,
                                    $urandom_range(65535) - 32768,
                                    $urandom_range(65535) - 32768, k == nv - 1);
                    cnt += nv;
                end
                else if ($urandom_range(19) == 0)
                begin
                    load_vertex($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
                    cnt++;
                end
                else
                begin
                    rand_route();
                    cnt++;
                end
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS offset_polygon_ray_route");
        else
            $display("FAIL offset_polygon_ray_route");
        $finish;
    end
endmodule
